// ----- rtl/kmsd_pkg.sv -----
// Shared types and constants of the keyboard macro stream decoder.
package kmsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    localparam logic [2:0] CFG_MACRO_COUNT  = 3'd0;
    localparam logic [2:0] CFG_BUFFER_SIZE  = 3'd1;
    localparam logic [2:0] CFG_SETTLE_DELAY = 3'd2;
    localparam logic [2:0] CFG_PREFIX_BYTE  = 3'd3;
    localparam logic [2:0] CFG_TAP_BYTE     = 3'd4;
    localparam logic [2:0] CFG_PRESS_BYTE   = 3'd5;
    localparam logic [2:0] CFG_RELEASE_BYTE = 3'd6;
    localparam logic [2:0] CFG_WAIT_BYTE    = 3'd7;

    typedef struct packed {
        logic [7:0]  macro_count;
        logic [15:0] buffer_size;
        logic [15:0] settle_delay;
        logic [7:0]  prefix_byte;
        logic [7:0]  tap_byte;
        logic [7:0]  press_byte;
        logic [7:0]  release_byte;
        logic [7:0]  wait_byte;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } event_t;

    typedef struct packed {
        logic [1:0]       count;
        event_t [2:0]     ev;
    } bundle_t;

endpackage

// ----- rtl/kmsd_front.sv -----
// Front end: accepts items, runs the parse state machine and builds event bundles.
module kmsd_front
    import kmsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        opcode,
    input  logic [7:0]  macro_number,
    input  logic [7:0]  data_byte,
    output logic        push,
    output bundle_t     bundle
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_PLAY  = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DELAY = 3'd5;

    localparam logic [2:0] EV_DELAY  = 3'd3;
    localparam logic [2:0] EV_SETTLE = 3'd4;
    localparam logic [2:0] EV_CHAR   = 3'd5;
    localparam logic [2:0] EV_DONE   = 3'd6;
    localparam logic [2:0] EV_ABORT  = 3'd7;

    localparam logic [1:0] CMD_TAP     = 2'd0;
    localparam logic [1:0] CMD_PRESS   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  skip_reg, skip_next;
    logic [1:0]  pend_reg, pend_next;
    logic [15:0] acc_reg, acc_next;

    logic        accept;
    logic [15:0] offset_inc;
    logic        at_end;
    logic        is_digit;
    logic [15:0] acc_step;
    logic [15:0] acc_prod;

    assign accept     = item_valid && item_ready;
    assign offset_inc = offset_reg + 16'd1;
    assign at_end     = offset_inc >= cfg.buffer_size;
    assign is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign acc_prod   = acc_reg * {12'd0, DECIMAL_BASE};
    assign acc_step   = acc_prod + {8'd0, data_byte - CHAR_ZERO};

    always_comb begin
        logic [1:0] n;
        logic       check_end;
        n           = 2'd0;
        check_end   = 1'b0;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        skip_next   = skip_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        bundle      = '0;
        if (opcode == 1'b0) begin
            if (macro_number >= cfg.macro_count || cfg.buffer_size == 16'd0
                    || data_byte != 8'd0) begin
                bundle.ev[n] = '{kind: EV_ABORT, value: 16'd0};
                n = n + 2'd1;
                phase_next = PH_IDLE;
            end else begin
                offset_next = 16'd0;
                skip_next   = macro_number;
                pend_next   = CMD_TAP;
                acc_next    = 16'd0;
                phase_next  = (macro_number != 8'd0) ? PH_SKIP : PH_PLAY;
            end
        end else if (phase_reg != PH_IDLE) begin
            check_end   = 1'b1;
            offset_next = offset_inc;
            unique case (phase_reg)
                PH_SKIP: begin
                    if (data_byte == 8'd0) begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg == 8'd1) begin
                            phase_next = PH_PLAY;
                        end
                    end
                end
                PH_PLAY: begin
                    if (data_byte == 8'd0) begin
                        bundle.ev[n] = '{kind: EV_DONE, value: 16'd0};
                        n = n + 2'd1;
                        phase_next = PH_IDLE;
                        check_end  = 1'b0;
                    end else if (data_byte == cfg.prefix_byte) begin
                        phase_next = PH_CMD;
                    end else begin
                        bundle.ev[n] = '{kind: EV_CHAR, value: {8'd0, data_byte}};
                        n = n + 2'd1;
                    end
                end
                PH_CMD: begin
                    priority if (data_byte == cfg.tap_byte) begin
                        pend_next  = CMD_TAP;
                        phase_next = PH_KEY;
                    end else if (data_byte == cfg.press_byte) begin
                        pend_next  = CMD_PRESS;
                        phase_next = PH_KEY;
                    end else if (data_byte == cfg.release_byte) begin
                        pend_next  = CMD_RELEASE;
                        phase_next = PH_KEY;
                    end else if (data_byte == cfg.wait_byte) begin
                        acc_next   = 16'd0;
                        phase_next = PH_DELAY;
                        if (at_end) begin
                            bundle.ev[n] = '{kind: EV_DELAY, value: 16'd0};
                            n = n + 2'd1;
                            bundle.ev[n] = '{kind: EV_SETTLE, value: cfg.settle_delay};
                            n = n + 2'd1;
                        end
                    end else begin
                        bundle.ev[n] = '{kind: EV_SETTLE, value: cfg.settle_delay};
                        n = n + 2'd1;
                        if (data_byte == 8'd0) begin
                            bundle.ev[n] = '{kind: EV_DONE, value: 16'd0};
                            n = n + 2'd1;
                            phase_next = PH_IDLE;
                            check_end  = 1'b0;
                        end else begin
                            phase_next = PH_PLAY;
                        end
                    end
                end
                PH_KEY: begin
                    bundle.ev[n] = '{kind: {1'b0, pend_reg}, value: {8'd0, data_byte}};
                    n = n + 2'd1;
                    bundle.ev[n] = '{kind: EV_SETTLE, value: cfg.settle_delay};
                    n = n + 2'd1;
                    phase_next = PH_PLAY;
                end
                PH_DELAY: begin
                    if (is_digit) begin
                        acc_next = acc_step;
                        if (at_end) begin
                            bundle.ev[n] = '{kind: EV_DELAY, value: acc_step};
                            n = n + 2'd1;
                            bundle.ev[n] = '{kind: EV_SETTLE, value: cfg.settle_delay};
                            n = n + 2'd1;
                        end
                    end else begin
                        bundle.ev[n] = '{kind: EV_DELAY, value: acc_reg};
                        n = n + 2'd1;
                        bundle.ev[n] = '{kind: EV_SETTLE, value: cfg.settle_delay};
                        n = n + 2'd1;
                        if (data_byte == 8'd0) begin
                            bundle.ev[n] = '{kind: EV_DONE, value: 16'd0};
                            n = n + 2'd1;
                            phase_next = PH_IDLE;
                            check_end  = 1'b0;
                        end else begin
                            phase_next = PH_PLAY;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    check_end  = 1'b0;
                end
            endcase
            if (check_end && phase_next != PH_IDLE && at_end) begin
                bundle.ev[n] = '{kind: EV_DONE, value: 16'd0};
                n = n + 2'd1;
                phase_next = PH_IDLE;
            end
        end
        bundle.count = n;
    end

    assign push = accept && (bundle.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            offset_reg <= 16'd0;
            skip_reg   <= 8'd0;
            pend_reg   <= CMD_TAP;
            acc_reg    <= 16'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            skip_reg   <= skip_next;
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// ----- rtl/kmsd_queue.sv -----
// Short bundle queue between the front end and the back end.
module kmsd_queue
    import kmsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head_data,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/kmsd_back.sv -----
// Back end: unpacks queued bundles into single result items in an output register.
module kmsd_back
    import kmsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head_data,
    input  logic        head_empty,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [15:0] m_event_value,
    output logic        m_last_event
);

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  kind_reg;
    logic [15:0] value_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;
    event_t      cur_ev;

    assign load    = !valid_reg || m_ready;
    assign cur_ev  = head_data.ev[idx_reg];
    assign is_last = idx_reg == (head_data.count - 2'd1);
    assign pop     = load && !head_empty && is_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = !head_empty;
            if (!head_empty) begin
                idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !head_empty) begin
            kind_reg  <= cur_ev.kind;
            value_reg <= cur_ev.value;
            last_reg  <= is_last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_event_kind  = kind_reg;
    assign m_event_value = value_reg;
    assign m_last_event  = last_reg;

endmodule

// ----- rtl/keyboard_macro_stream_decoder.sv -----
// Top level of the keyboard macro stream decoder: registers, front end, queue, back end.
//
//   Channel  Ports                                        Role
//   s_       s_valid s_ready s_opcode s_macro_number ...  input items (start or buffer byte)
//   m_       m_valid m_ready m_event_kind m_event_value   result items, m_last_event marks end
//   cfg_     cfg_wr_en cfg_index cfg_data                 register writes, no wait
//
// An input item is taken while s_ready is high; its zero to three results pass the bundle
// queue and leave the output register one per cycle while m_ready is high. With m_ready
// high, the sustained input rate is one item per cycle while items cause at most one
// result each; items with more results are paced by the back end's one-result-per-cycle
// unpacking. Reset clears the parse state, the queue and the output valid flag; registers
// take defaults. The input stalls only while the bundle queue is full.
module keyboard_macro_stream_decoder
    import kmsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_macro_number,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [15:0] m_event_value,
    output logic        m_last_event,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t       cfg_reg;
    bundle_t    push_bundle;
    bundle_t    head_bundle;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.macro_count  <= 8'd16;
            cfg_reg.buffer_size  <= 16'd1024;
            cfg_reg.settle_delay <= 16'd0;
            cfg_reg.prefix_byte  <= 8'd1;
            cfg_reg.tap_byte     <= 8'd1;
            cfg_reg.press_byte   <= 8'd2;
            cfg_reg.release_byte <= 8'd3;
            cfg_reg.wait_byte    <= 8'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MACRO_COUNT:  cfg_reg.macro_count  <= cfg_data[7:0];
                CFG_BUFFER_SIZE:  cfg_reg.buffer_size  <= cfg_data;
                CFG_SETTLE_DELAY: cfg_reg.settle_delay <= cfg_data;
                CFG_PREFIX_BYTE:  cfg_reg.prefix_byte  <= cfg_data[7:0];
                CFG_TAP_BYTE:     cfg_reg.tap_byte     <= cfg_data[7:0];
                CFG_PRESS_BYTE:   cfg_reg.press_byte   <= cfg_data[7:0];
                CFG_RELEASE_BYTE: cfg_reg.release_byte <= cfg_data[7:0];
                CFG_WAIT_BYTE:    cfg_reg.wait_byte    <= cfg_data[7:0];
                default:          cfg_reg.wait_byte    <= cfg_reg.wait_byte;
            endcase
        end
    end

    assign s_ready = !q_full;

    kmsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .item_valid   (s_valid),
        .item_ready   (s_ready),
        .opcode       (s_opcode),
        .macro_number (s_macro_number),
        .data_byte    (s_data_byte),
        .push         (q_push),
        .bundle       (push_bundle)
    );

    kmsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_bundle),
        .pop       (q_pop),
        .head_data (head_bundle),
        .full      (q_full),
        .empty     (q_empty)
    );

    kmsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_data     (head_bundle),
        .head_empty    (q_empty),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_value (m_event_value),
        .m_last_event  (m_last_event)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the keyboard macro stream decoder with an in-bench event predictor.
module tb_top
    import kmsd_pkg::*;
();

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;

    typedef enum logic [2:0] {
        EV_TAP, EV_PRESS, EV_RELEASE, EV_DELAY, EV_SETTLE, EV_CHAR, EV_DONE, EV_ABORT
    } ev_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SKIP, PH_PLAY, PH_CMD, PH_KEY, PH_DELAY
    } play_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        last;
    } event_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [7:0]  s_macro_number;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_kind;
    logic [15:0] m_event_value;
    logic        m_last_event;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cfg_t        active_cfg;
    play_phase_t play_phase = PH_IDLE;
    logic [15:0] byte_pos   = '0;
    logic [7:0]  skip_left  = '0;
    ev_kind_t    key_kind   = EV_TAP;
    logic [15:0] delay_acc  = '0;

    event_rec_t  awaited_events[$];
    int          useful_items = 0;
    int          mismatches   = 0;
    bit          steady_tx    = 1'b0;
    bit          steady_rx    = 1'b0;
    bit          hold_req     = 1'b0;

    keyboard_macro_stream_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_macro_number (s_macro_number),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_value  (m_event_value),
        .m_last_event   (m_last_event),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_event(input ev_kind_t kind, input logic [15:0] value);
        event_rec_t e;
        e.kind  = kind;
        e.value = value;
        e.last  = 1'b0;
        awaited_events.push_back(e);
    endfunction

    task automatic decode_item(input logic op, input logic [7:0] num, input logic [7:0] b);
        int         first;
        bit         end_check;
        event_rec_t tail;
        first = awaited_events.size();
        if (op == OP_START || play_phase != PH_IDLE) useful_items++;
        if (op == OP_START) begin
            if (num >= active_cfg.macro_count || active_cfg.buffer_size == 16'd0
                    || b != 8'd0) begin
                add_event(EV_ABORT, 16'd0);
                play_phase = PH_IDLE;
            end else begin
                byte_pos  = '0;
                skip_left = num;
                key_kind  = EV_TAP;
                delay_acc = '0;
                if (num != 8'd0) play_phase = PH_SKIP;
                else play_phase = PH_PLAY;
            end
        end else if (play_phase != PH_IDLE) begin
            end_check = 1'b1;
            byte_pos = byte_pos + 16'd1;
            case (play_phase)
                PH_SKIP: begin
                    if (b == 8'd0) begin
                        skip_left = skip_left - 8'd1;
                        if (skip_left == 8'd0) play_phase = PH_PLAY;
                    end
                end
                PH_PLAY: begin
                    if (b == 8'd0) begin
                        add_event(EV_DONE, 16'd0);
                        play_phase = PH_IDLE;
                        end_check = 1'b0;
                    end else if (b == active_cfg.prefix_byte) begin
                        play_phase = PH_CMD;
                    end else begin
                        add_event(EV_CHAR, {8'd0, b});
                    end
                end
                PH_CMD: begin
                    if (b == active_cfg.tap_byte) begin
                        key_kind = EV_TAP;
                        play_phase = PH_KEY;
                    end else if (b == active_cfg.press_byte) begin
                        key_kind = EV_PRESS;
                        play_phase = PH_KEY;
                    end else if (b == active_cfg.release_byte) begin
                        key_kind = EV_RELEASE;
                        play_phase = PH_KEY;
                    end else if (b == active_cfg.wait_byte) begin
                        delay_acc = '0;
                        play_phase = PH_DELAY;
                        if (byte_pos >= active_cfg.buffer_size) begin
                            add_event(EV_DELAY, 16'd0);
                            add_event(EV_SETTLE, active_cfg.settle_delay);
                        end
                    end else begin
                        add_event(EV_SETTLE, active_cfg.settle_delay);
                        if (b == 8'd0) begin
                            add_event(EV_DONE, 16'd0);
                            play_phase = PH_IDLE;
                            end_check = 1'b0;
                        end else begin
                            play_phase = PH_PLAY;
                        end
                    end
                end
                PH_KEY: begin
                    add_event(key_kind, {8'd0, b});
                    add_event(EV_SETTLE, active_cfg.settle_delay);
                    play_phase = PH_PLAY;
                end
                PH_DELAY: begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        delay_acc = delay_acc * DECIMAL_BASE + (b - CHAR_ZERO);
                        if (byte_pos >= active_cfg.buffer_size) begin
                            add_event(EV_DELAY, delay_acc);
                            add_event(EV_SETTLE, active_cfg.settle_delay);
                        end
                    end else begin
                        add_event(EV_DELAY, delay_acc);
                        add_event(EV_SETTLE, active_cfg.settle_delay);
                        if (b == 8'd0) begin
                            add_event(EV_DONE, 16'd0);
                            play_phase = PH_IDLE;
                            end_check = 1'b0;
                        end else begin
                            play_phase = PH_PLAY;
                        end
                    end
                end
                default: begin
                    play_phase = PH_IDLE;
                    end_check = 1'b0;
                end
            endcase
            if (end_check && play_phase != PH_IDLE && byte_pos >= active_cfg.buffer_size) begin
                add_event(EV_DONE, 16'd0);
                play_phase = PH_IDLE;
            end
        end
        if (awaited_events.size() > first) begin
            tail = awaited_events.pop_back();
            tail.last = 1'b1;
            awaited_events.push_back(tail);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] num, input logic [7:0] b);
        int gap;
        gap = steady_tx ? 0 : gap_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_macro_number <= num;
        s_data_byte    <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_item(op, num, b);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, 8'($urandom), b);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic load_config(input cfg_t c);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(CFG_MACRO_COUNT, {junk, c.macro_count});
        write_reg(CFG_BUFFER_SIZE, c.buffer_size);
        write_reg(CFG_SETTLE_DELAY, c.settle_delay);
        write_reg(CFG_PREFIX_BYTE, {junk, c.prefix_byte});
        write_reg(CFG_TAP_BYTE, {~junk, c.tap_byte});
        write_reg(CFG_PRESS_BYTE, {junk, c.press_byte});
        write_reg(CFG_RELEASE_BYTE, {~junk, c.release_byte});
        write_reg(CFG_WAIT_BYTE, {junk, c.wait_byte});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = c;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == active_cfg.prefix_byte) b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    function automatic logic [7:0] delay_end_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) return 8'd0;
        b = 8'($urandom);
        while (b >= CHAR_ZERO && b <= CHAR_NINE) b = 8'($urandom);
        return b;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.macro_count  = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
        c.buffer_size  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 40));
        c.settle_delay = 16'($urandom);
        c.prefix_byte  = 8'($urandom_range(1, 255));
        c.tap_byte     = 8'($urandom);
        c.press_byte   = ($urandom_range(0, 3) == 0) ? c.tap_byte : 8'($urandom);
        c.release_byte = 8'($urandom);
        c.wait_byte    = 8'($urandom);
        return c;
    endfunction

    task automatic play_random_macro();
        int skips;
        int tokens;
        int n;
        int k;
        case ($urandom_range(0, 9))
            0: send_item(OP_START, 8'($urandom), 8'($urandom));
            1: send_byte(8'($urandom));
            default: begin
                if (active_cfg.macro_count == 8'd0) skips = 0;
                else if (active_cfg.macro_count > 8'd3) skips = $urandom_range(0, 3);
                else skips = $urandom_range(0, active_cfg.macro_count - 1);
                send_item(OP_START, 8'(skips), 8'h00);
                for (k = 0; k < skips && play_phase != PH_IDLE; k++) begin
                    n = $urandom_range(0, 3);
                    repeat (n) send_byte(plain_byte());
                    send_byte(8'h00);
                end
                tokens = $urandom_range(1, 8);
                k = 0;
                while (k < tokens && play_phase != PH_IDLE) begin
                    k++;
                    case ($urandom_range(0, 11))
                        0, 1, 2, 3: send_byte(plain_byte());
                        4, 5: begin
                            send_byte(active_cfg.prefix_byte);
                            case ($urandom_range(0, 2))
                                0: send_byte(active_cfg.tap_byte);
                                1: send_byte(active_cfg.press_byte);
                                default: send_byte(active_cfg.release_byte);
                            endcase
                            send_byte(8'($urandom));
                        end
                        6, 7: begin
                            send_byte(active_cfg.prefix_byte);
                            send_byte(active_cfg.wait_byte);
                            n = $urandom_range(1, 6);
                            repeat (n) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                            send_byte(delay_end_byte());
                        end
                        8: begin
                            send_byte(active_cfg.prefix_byte);
                            send_byte(8'($urandom));
                        end
                        9: send_byte(8'($urandom));
                        10: send_item(OP_START, 8'h00, 8'h00);
                        default: begin
                            send_byte(active_cfg.prefix_byte);
                            send_byte(8'h00);
                        end
                    endcase
                end
                if (play_phase != PH_IDLE && $urandom_range(0, 4) != 0) send_byte(8'h00);
            end
        endcase
    endtask

    task automatic test_rejected_starts();
        send_item(OP_START, 8'd255, 8'h00);
        send_item(OP_START, 8'h00, 8'hFF);
        drain_results();
    endtask

    task automatic test_command_decoding();
        int k;
        send_item(OP_START, 8'h00, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h03);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
        // 99999 wraps to 34463 and the zero byte ending the delay also ends playback.
        send_byte(8'h01);
        send_byte(8'h04);
        for (k = 0; k < 5; k++) send_byte(CHAR_NINE);
        send_byte(8'h00);
        send_byte(8'h41);
        drain_results();
    endtask

    task automatic test_buffer_edges();
        cfg_t c;
        c.macro_count  = 8'd255;
        c.buffer_size  = 16'd4;
        c.settle_delay = 16'hFFFF;
        c.prefix_byte  = 8'hFF;
        c.tap_byte     = 8'h80;
        c.press_byte   = 8'h80;
        c.release_byte = 8'h00;
        c.wait_byte    = 8'h7F;
        load_config(c);
        send_item(OP_START, 8'h01, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h11);
        drain_results();
    endtask

    task automatic test_input_backpressure();
        cfg_t c;
        int   k;
        c = {8'd16, 16'd1024, 16'h1234, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4};
        load_config(c);
        hold_req  = 1'b1;
        steady_tx = 1'b1;
        send_item(OP_START, 8'h00, 8'h00);
        for (k = 0; k < 12; k++) begin
            send_byte(c.prefix_byte);
            send_byte(c.tap_byte);
            send_byte(8'(k * 21));
        end
        steady_tx = 1'b0;
        drain_results();
    endtask

    task automatic test_random_playback();
        cfg_t c;
        int   p;
        int   goal;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: c = {8'd255, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB};
                1: c = '0;
                default: c = random_config();
            endcase
            steady_tx = (p == 4);
            steady_rx = (p == 4);
            load_config(c);
            goal = useful_items + ((p == 1) ? 10 : 45);
            while (useful_items < goal) play_random_macro();
            drain_results();
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    initial begin : result_receiver
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (steady_rx || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                stall = gap_length() + 1;
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : event_compare
        event_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d value %0d last %0d",
                             m_event_kind, m_event_value, m_last_event);
            end else begin
                want = awaited_events.pop_front();
                if (m_event_kind !== want.kind || m_event_value !== want.value ||
                    m_last_event !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"event mismatch: expected kind %0d value %0d last %0d, ",
                                  "got kind %0d value %0d last %0d"},
                                 want.kind, want.value, want.last,
                                 m_event_kind, m_event_value, m_last_event);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        s_valid        = 1'b0;
        s_opcode       = OP_START;
        s_macro_number = 8'h00;
        s_data_byte    = 8'h00;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_MACRO_COUNT;
        cfg_data       = 16'h0000;
        active_cfg     = {8'd16, 16'd1024, 16'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4};
        aresetn        = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_rejected_starts();
        test_command_decoding();
        test_buffer_edges();
        test_input_backpressure();
        test_random_playback();

        if (mismatches == 0 && awaited_events.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kmsd_pkg.sv
rtl/kmsd_front.sv
rtl/kmsd_queue.sv
rtl/kmsd_back.sv
rtl/keyboard_macro_stream_decoder.sv
tb/tb_top.sv
